// File: design/lodc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lodc_pkg
// Shared types and codes for the lock-order deadlock checker.
// ----------------------------------------------------------------------------
package lodc_pkg;

   localparam int unsigned ADDR_W     = 48;
   localparam int unsigned CPU_FIELD_W = 8;
   localparam int unsigned DEPTH_OUT_W = 5;
   localparam int unsigned EDGE_OUT_W  = 9;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_SKIPPED      = 3'd1,
      ST_RECURSIVE    = 3'd2,
      ST_CYCLE        = 3'd3,
      ST_OVERFLOW     = 3'd4,
      ST_OUT_OF_ORDER = 3'd5,
      ST_NOT_HELD     = 3'd6,
      ST_HALTED       = 3'd7
   } status_type;

   typedef struct packed {
      logic                   opcode;
      logic [CPU_FIELD_W-1:0] cpu;
      logic [ADDR_W-1:0]      lock_addr;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [ADDR_W-1:0]      conflict_addr;
      logic [DEPTH_OUT_W-1:0] held_depth;
      logic [EDGE_OUT_W-1:0]  edge_total;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_R_RD, S_R_CHK,
      S_CY_RD, S_CY_LD,
      S_P_POP, S_P_POPD, S_P_EREAD, S_P_ECHK,
      S_V_RD, S_V_CHK,
      S_E_RD, S_E_LD, S_D_RD, S_D_CHK,
      S_PUSH,
      S_L_TOP, S_L_TOPCHK, S_L_RD, S_L_CHK,
      S_C_RD, S_C_WR,
      S_FINISH
   } fsm_type;

endpackage
`default_nettype wire

// File: design/lock_order_deadlock_checker.sv
// Skipped or halted items go straight to the result register. An acquire runs
// the recursion scan, then a walk for each held lock, then edge insertion; a
// release searches the held stack and compacts it.
// One item at a time: the next beat is taken once the result is registered.
// Reset clears control, per-CPU counts, edge count and halted; RAMs keep junk.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lock_order_deadlock_checker
// Per-CPU held-lock stacks and a global lock-order edge table, checked by a
// sequencer around one shared set of RAM read ports and comparators.
// ----------------------------------------------------------------------------
module lock_order_deadlock_checker #(
   parameter int unsigned NUM_CPUS  = 8,
   parameter int unsigned MAX_HELD  = 16,
   parameter int unsigned MAX_EDGES = 256,
   parameter int unsigned DFS_LIMIT = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lodc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lodc_pkg::rsp_type     rsp_data
);

   localparam int unsigned AW    = lodc_pkg::ADDR_W;
   localparam int unsigned CPU_W = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
   localparam int unsigned DW    = $clog2(MAX_HELD + 1);
   localparam int unsigned EW    = $clog2(MAX_EDGES + 1);
   localparam int unsigned VW    = $clog2(DFS_LIMIT + 1);
   localparam int unsigned HDEP  = NUM_CPUS * MAX_HELD;
   localparam int unsigned HAW   = HDEP > 1 ? $clog2(HDEP) : 1;
   localparam int unsigned EAW   = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned WAW   = DFS_LIMIT > 1 ? $clog2(DFS_LIMIT) : 1;

   lodc_pkg::fsm_type    state_ff, state_in;
   logic                 cpu_ok_ff, cpu_ok_in;
   logic [CPU_W-1:0]     cpu_ff, cpu_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [DW-1:0]        depth_ff, depth_in;
   lodc_pkg::status_type status_ff, status_in;
   logic [AW-1:0]        conflict_ff, conflict_in;
   logic [DW-1:0]        i_ff, i_in;
   logic [EW-1:0]        e_ff, e_in;
   logic [VW-1:0]        j_ff, j_in;
   logic [VW-1:0]        sp_ff, sp_in;
   logic [VW-1:0]        nvis_ff, nvis_in;
   logic [AW-1:0]        key_ff, key_in;
   logic [AW-1:0]        cur_ff, cur_in;
   logic [AW-1:0]        nxt_ff, nxt_in;
   logic [EW-1:0]        edge_cnt_ff, edge_cnt_in;
   logic                 halted_ff, halted_in;
   logic [DW-1:0]        counts_ff [NUM_CPUS];
   logic                 counts_we;
   logic                 rsp_valid_ff, rsp_valid_in;
   lodc_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                 req_cpu_ok;
   logic [CPU_W-1:0]     req_cpu_idx;

   // RAM ports
   logic [DW-1:0]  held_rd_off, held_wr_off;
   logic           held_we;
   logic [AW-1:0]  held_wr_data, held_rd_data;
   logic [HAW-1:0] held_rd_addr, held_wr_addr;
   logic [EAW-1:0] edge_rd_addr, edge_wr_addr;
   logic           edge_we;
   logic [AW-1:0]  esrc_rd_data, etgt_rd_data;
   logic [WAW-1:0] vis_rd_addr, vis_wr_addr, stk_rd_addr, stk_wr_addr;
   logic           walk_we;
   logic [AW-1:0]  walk_wr_data, vis_rd_data, stk_rd_data;

   assign req_cpu_ok   = req_data.cpu < lodc_pkg::CPU_FIELD_W'(NUM_CPUS);
   assign req_cpu_idx  = CPU_W'(req_data.cpu);
   assign held_rd_addr = HAW'(cpu_ff * MAX_HELD + held_rd_off);
   assign held_wr_addr = HAW'(cpu_ff * MAX_HELD + held_wr_off);
   assign edge_wr_addr = EAW'(edge_cnt_ff);

   lodc_ram #(.WIDTH(AW), .DEPTH(HDEP)) u_held (
      .clock(clock), .wr_en(held_we), .wr_addr(held_wr_addr), .wr_data(held_wr_data),
      .rd_addr(held_rd_addr), .rd_data(held_rd_data)
   );
   lodc_ram #(.WIDTH(AW), .DEPTH(MAX_EDGES)) u_esrc (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wr_addr), .wr_data(key_ff),
      .rd_addr(edge_rd_addr), .rd_data(esrc_rd_data)
   );
   lodc_ram #(.WIDTH(AW), .DEPTH(MAX_EDGES)) u_etgt (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wr_addr), .wr_data(addr_ff),
      .rd_addr(edge_rd_addr), .rd_data(etgt_rd_data)
   );
   lodc_ram #(.WIDTH(AW), .DEPTH(DFS_LIMIT)) u_wvis (
      .clock(clock), .wr_en(walk_we), .wr_addr(vis_wr_addr), .wr_data(walk_wr_data),
      .rd_addr(vis_rd_addr), .rd_data(vis_rd_data)
   );
   lodc_ram #(.WIDTH(AW), .DEPTH(DFS_LIMIT)) u_wstk (
      .clock(clock), .wr_en(walk_we), .wr_addr(stk_wr_addr), .wr_data(walk_wr_data),
      .rd_addr(stk_rd_addr), .rd_data(stk_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lodc_pkg::S_IDLE;
         edge_cnt_ff  <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_CPUS; k++) begin
            counts_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         edge_cnt_ff  <= edge_cnt_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (counts_we) begin
            counts_ff[cpu_ff] <= depth_ff;
         end
      end
      cpu_ok_ff   <= cpu_ok_in;
      cpu_ff      <= cpu_in;
      addr_ff     <= addr_in;
      depth_ff    <= depth_in;
      status_ff   <= status_in;
      conflict_ff <= conflict_in;
      i_ff        <= i_in;
      e_ff        <= e_in;
      j_ff        <= j_in;
      sp_ff       <= sp_in;
      nvis_ff     <= nvis_in;
      key_ff      <= key_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cpu_ok_in    = cpu_ok_ff;
      cpu_in       = cpu_ff;
      addr_in      = addr_ff;
      depth_in     = depth_ff;
      status_in    = status_ff;
      conflict_in  = conflict_ff;
      i_in         = i_ff;
      e_in         = e_ff;
      j_in         = j_ff;
      sp_in        = sp_ff;
      nvis_in      = nvis_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      edge_cnt_in  = edge_cnt_ff;
      halted_in    = halted_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      counts_we    = 1'b0;
      req_stall    = 1'b1;
      held_rd_off  = i_ff;
      held_wr_off  = i_ff;
      held_we      = 1'b0;
      held_wr_data = addr_ff;
      edge_rd_addr = EAW'(e_ff);
      edge_we      = 1'b0;
      vis_rd_addr  = WAW'(j_ff);
      stk_rd_addr  = WAW'(sp_ff - VW'(1));
      vis_wr_addr  = WAW'(nvis_ff);
      stk_wr_addr  = WAW'(sp_ff);
      walk_we      = 1'b0;
      walk_wr_data = nxt_ff;

      unique case (state_ff)
         lodc_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cpu_ok_in   = req_cpu_ok;
               cpu_in      = req_cpu_idx;
               addr_in     = req_data.lock_addr;
               depth_in    = req_cpu_ok ? counts_ff[req_cpu_idx] : '0;
               status_in   = lodc_pkg::ST_OK;
               conflict_in = '0;
               i_in        = '0;
               if (!req_cpu_ok) begin
                  status_in = halted_ff ? lodc_pkg::ST_HALTED : lodc_pkg::ST_SKIPPED;
                  state_in  = lodc_pkg::S_FINISH;
               end else if (halted_ff) begin
                  status_in = lodc_pkg::ST_HALTED;
                  state_in  = lodc_pkg::S_FINISH;
               end else if (req_data.opcode == lodc_pkg::OP_ACQUIRE) begin
                  state_in = lodc_pkg::S_R_RD;
               end else begin
                  state_in = lodc_pkg::S_L_TOP;
               end
            end
         end
         // recursive acquire scan
         lodc_pkg::S_R_RD: begin
            if (i_ff == depth_ff) begin
               i_in     = '0;
               state_in = lodc_pkg::S_CY_RD;
            end else begin
               state_in = lodc_pkg::S_R_CHK;
            end
         end
         lodc_pkg::S_R_CHK: begin
            if (held_rd_data == addr_ff) begin
               status_in = lodc_pkg::ST_RECURSIVE;
               halted_in = 1'b1;
               state_in  = lodc_pkg::S_FINISH;
            end else begin
               i_in     = i_ff + DW'(1);
               state_in = lodc_pkg::S_R_RD;
            end
         end
         // cycle check, one walk per held lock
         lodc_pkg::S_CY_RD: begin
            if (i_ff == depth_ff) begin
               i_in     = '0;
               state_in = lodc_pkg::S_E_RD;
            end else begin
               state_in = lodc_pkg::S_CY_LD;
            end
         end
         lodc_pkg::S_CY_LD: begin
            if (held_rd_data == addr_ff) begin
               status_in   = lodc_pkg::ST_CYCLE;
               conflict_in = held_rd_data;
               halted_in   = 1'b1;
               state_in    = lodc_pkg::S_FINISH;
            end else begin
               key_in       = held_rd_data;
               walk_we      = 1'b1;
               vis_wr_addr  = '0;
               stk_wr_addr  = '0;
               walk_wr_data = addr_ff;
               sp_in        = VW'(1);
               nvis_in      = VW'(1);
               state_in     = lodc_pkg::S_P_POP;
            end
         end
         lodc_pkg::S_P_POP: begin
            if (sp_ff == '0) begin
               i_in     = i_ff + DW'(1);
               state_in = lodc_pkg::S_CY_RD;
            end else begin
               sp_in    = sp_ff - VW'(1);
               state_in = lodc_pkg::S_P_POPD;
            end
         end
         lodc_pkg::S_P_POPD: begin
            cur_in   = stk_rd_data;
            e_in     = '0;
            state_in = lodc_pkg::S_P_EREAD;
         end
         lodc_pkg::S_P_EREAD: begin
            if (e_ff == edge_cnt_ff) begin
               state_in = lodc_pkg::S_P_POP;
            end else begin
               state_in = lodc_pkg::S_P_ECHK;
            end
         end
         lodc_pkg::S_P_ECHK: begin
            if (esrc_rd_data != cur_ff) begin
               e_in     = e_ff + EW'(1);
               state_in = lodc_pkg::S_P_EREAD;
            end else if (etgt_rd_data == key_ff) begin
               status_in   = lodc_pkg::ST_CYCLE;
               conflict_in = key_ff;
               halted_in   = 1'b1;
               state_in    = lodc_pkg::S_FINISH;
            end else begin
               nxt_in   = etgt_rd_data;
               j_in     = '0;
               state_in = lodc_pkg::S_V_RD;
            end
         end
         lodc_pkg::S_V_RD: begin
            if (j_ff == nvis_ff) begin
               // unseen: keep it only while both lists have room
               if (nvis_ff < VW'(DFS_LIMIT) && sp_ff < VW'(DFS_LIMIT)) begin
                  walk_we = 1'b1;
                  nvis_in = nvis_ff + VW'(1);
                  sp_in   = sp_ff + VW'(1);
               end
               e_in     = e_ff + EW'(1);
               state_in = lodc_pkg::S_P_EREAD;
            end else begin
               state_in = lodc_pkg::S_V_CHK;
            end
         end
         lodc_pkg::S_V_CHK: begin
            if (vis_rd_data == nxt_ff) begin
               e_in     = e_ff + EW'(1);
               state_in = lodc_pkg::S_P_EREAD;
            end else begin
               j_in     = j_ff + VW'(1);
               state_in = lodc_pkg::S_V_RD;
            end
         end
         // edge insertion
         lodc_pkg::S_E_RD: begin
            if (i_ff == depth_ff) begin
               state_in = lodc_pkg::S_PUSH;
            end else begin
               state_in = lodc_pkg::S_E_LD;
            end
         end
         lodc_pkg::S_E_LD: begin
            key_in   = held_rd_data;
            e_in     = '0;
            state_in = lodc_pkg::S_D_RD;
         end
         lodc_pkg::S_D_RD: begin
            if (e_ff == edge_cnt_ff) begin
               if (edge_cnt_ff < EW'(MAX_EDGES)) begin
                  edge_we     = 1'b1;
                  edge_cnt_in = edge_cnt_ff + EW'(1);
               end
               i_in     = i_ff + DW'(1);
               state_in = lodc_pkg::S_E_RD;
            end else begin
               state_in = lodc_pkg::S_D_CHK;
            end
         end
         lodc_pkg::S_D_CHK: begin
            if (esrc_rd_data == key_ff && etgt_rd_data == addr_ff) begin
               i_in     = i_ff + DW'(1);
               state_in = lodc_pkg::S_E_RD;
            end else begin
               e_in     = e_ff + EW'(1);
               state_in = lodc_pkg::S_D_RD;
            end
         end
         lodc_pkg::S_PUSH: begin
            if (depth_ff >= DW'(MAX_HELD)) begin
               status_in = lodc_pkg::ST_OVERFLOW;
               halted_in = 1'b1;
            end else begin
               held_we     = 1'b1;
               held_wr_off = depth_ff;
               depth_in    = depth_ff + DW'(1);
            end
            state_in = lodc_pkg::S_FINISH;
         end
         // release
         lodc_pkg::S_L_TOP: begin
            held_rd_off = depth_ff - DW'(1);
            if (depth_ff == '0) begin
               status_in = lodc_pkg::ST_NOT_HELD;
               state_in  = lodc_pkg::S_FINISH;
            end else begin
               state_in = lodc_pkg::S_L_TOPCHK;
            end
         end
         lodc_pkg::S_L_TOPCHK: begin
            if (held_rd_data == addr_ff) begin
               depth_in = depth_ff - DW'(1);
               state_in = lodc_pkg::S_FINISH;
            end else begin
               i_in     = '0;
               state_in = lodc_pkg::S_L_RD;
            end
         end
         lodc_pkg::S_L_RD: begin
            if (i_ff == depth_ff) begin
               status_in = lodc_pkg::ST_NOT_HELD;
               state_in  = lodc_pkg::S_FINISH;
            end else begin
               state_in = lodc_pkg::S_L_CHK;
            end
         end
         lodc_pkg::S_L_CHK: begin
            if (held_rd_data == addr_ff) begin
               state_in = lodc_pkg::S_C_RD;
            end else begin
               i_in     = i_ff + DW'(1);
               state_in = lodc_pkg::S_L_RD;
            end
         end
         // compact: slide entries above i down by one
         lodc_pkg::S_C_RD: begin
            held_rd_off = i_ff + DW'(1);
            if (i_ff == depth_ff - DW'(1)) begin
               depth_in  = depth_ff - DW'(1);
               status_in = lodc_pkg::ST_OUT_OF_ORDER;
               state_in  = lodc_pkg::S_FINISH;
            end else begin
               state_in = lodc_pkg::S_C_WR;
            end
         end
         lodc_pkg::S_C_WR: begin
            held_we      = 1'b1;
            held_wr_data = held_rd_data;
            i_in         = i_ff + DW'(1);
            state_in     = lodc_pkg::S_C_RD;
         end
         lodc_pkg::S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.conflict_addr = conflict_ff;
               rsp_data_in.held_depth    = lodc_pkg::DEPTH_OUT_W'(depth_ff);
               rsp_data_in.edge_total    = lodc_pkg::EDGE_OUT_W'(edge_cnt_ff);
               counts_we                 = cpu_ok_ff;
               state_in                  = lodc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lodc_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_halted_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag dropped");
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != lodc_pkg::S_IDLE |-> edge_cnt_ff <= EW'(MAX_EDGES))
      else $error("edge count above table size");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == lodc_pkg::S_V_RD |-> sp_ff <= VW'(DFS_LIMIT) && nvis_ff <= VW'(DFS_LIMIT))
      else $error("walk lists overran");
   a_out_halted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff) && rsp_data_ff.status == lodc_pkg::ST_HALTED)
      |-> halted_ff)
      else $error("halted status without halted flag");
`endif

endmodule
`default_nettype wire

// File: design/lodc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lodc_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lodc_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
